>>> hw/rtl/erld_pkg.sv
`default_nettype none

package erld_pkg;

  // escape marker of the byte-encoded stream
  localparam logic [7:0] EscByte = 8'h80;

  // configuration register indexes
  localparam logic CfgLineBytes = 1'b0;
  localparam logic CfgRleEnable = 1'b1;

  // decode phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,  // expecting literal or escape
    PH_COUNT = 3'b010,  // expecting count after escape
    PH_VALUE = 3'b100   // expecting run value
  } phase_e;

  // result of decoding one byte against the current state
  typedef struct packed {
    logic        emit;
    logic [7:0]  value;
    logic [8:0]  repeat_res;
    logic        line_end;
    phase_e      phase_nxt;
    logic [7:0]  run_count_nxt;
    logic [15:0] bytes_left_nxt;
  } dec_t;

endpackage

`default_nettype wire

>>> hw/rtl/erld_decode.sv
`default_nettype none

module erld_decode import erld_pkg::*; (
  input  var phase_e      phase_i,
  input  var logic [7:0]  run_count_i,
  input  var logic [15:0] bytes_left_i,
  input  var logic [15:0] line_bytes_i,
  input  var logic        rle_enable_i,
  input  var logic [7:0]  code_byte_i,
  output dec_t            dec_o
);

  logic        emit;
  logic [7:0]  run_val;
  logic [8:0]  run_len;
  phase_e      phase_nxt;
  logic [7:0]  count_nxt;
  logic [15:0] left;
  logic [15:0] len_ext;
  logic [15:0] rep_ext;
  logic [15:0] left_nxt;

  // phase machine and run selection
  always_comb begin
    emit      = 1'b0;
    run_val   = code_byte_i;
    run_len   = 9'd1;
    phase_nxt = PH_IDLE;
    count_nxt = run_count_i;
    if (!rle_enable_i) begin
      emit = 1'b1;
    end else begin
      unique case (phase_i)
        PH_COUNT: begin
          if (code_byte_i == 8'd0) begin
            emit    = 1'b1;
            run_val = EscByte;
          end else begin
            count_nxt = code_byte_i;
            phase_nxt = PH_VALUE;
          end
        end
        PH_VALUE: begin
          emit    = 1'b1;
          run_len = {1'b0, run_count_i} + 9'd1;
        end
        default: begin
          if (code_byte_i == EscByte) begin
            phase_nxt = PH_COUNT;
          end else begin
            emit = 1'b1;
          end
        end
      endcase
    end
  end

  // cut the run at the end of the line, reloading at a line start
  always_comb begin
    if (bytes_left_i != 16'd0) begin
      left = bytes_left_i;
    end else if (line_bytes_i != 16'd0) begin
      left = line_bytes_i;
    end else begin
      left = 16'd1;
    end
    len_ext  = {7'd0, run_len};
    rep_ext  = (len_ext < left) ? len_ext : left;
    left_nxt = left - rep_ext;
  end

  always_comb begin
    dec_o.emit          = emit;
    dec_o.value         = run_val;
    dec_o.repeat_res    = rep_ext[8:0];
    dec_o.line_end      = (left_nxt == 16'd0);
    dec_o.phase_nxt     = phase_nxt;
    dec_o.run_count_nxt = count_nxt;
    dec_o.bytes_left_nxt = emit ? left_nxt : bytes_left_i;
  end

endmodule

`default_nettype wire

>>> hw/rtl/escape_rle_line_decoder.sv
// Escape run-length line decoder. Takes one encoded byte per cycle on the
// input channel and returns one run (value, repeat count, line end) for each
// literal, escaped escape or completed escape run; escape and count bytes
// return nothing while rle_enable is set. A byte goes through an input register
// and a result register; a new byte is accepted every cycle as long as the
// result register is free or being taken. line_bytes and rle_enable are written
// through the plain write port while the block is idle (a user rule the block
// does not enforce); a new line length applies from the next line start.

`default_nettype none

module escape_rle_line_decoder import erld_pkg::*; (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  // configuration
  input  var logic        cfg_we_i,
  input  var logic        cfg_idx_i,
  input  var logic [15:0] cfg_wdata_i,
  // encoded bytes
  input  var logic        in_valid_i,
  output logic            in_ready_o,
  input  var logic [7:0]  code_byte_i,
  // decoded runs
  output logic            out_valid_o,
  input  var logic        out_ready_i,
  output logic [7:0]      value_o,
  output logic [8:0]      repeat_res_o,
  output logic            line_end_o
);

  logic [15:0] line_bytes_q;
  logic        rle_enable_q;
  phase_e      phase_q;
  logic [7:0]  run_count_q;
  logic [15:0] bytes_left_q;
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        out_valid_q;
  logic [7:0]  out_value_q;
  logic [8:0]  out_repeat_q;
  logic        out_line_end_q;
  dec_t        dec;
  logic        out_free;
  logic        s1_fire;
  logic        res_load;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_bytes_q <= 16'd1;
      rle_enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLineBytes: line_bytes_q <= cfg_wdata_i;
        CfgRleEnable: rle_enable_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // handshake between stages
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && (!dec.emit || out_free);
  assign res_load   = s1_fire && dec.emit;
  assign in_ready_o = !s1_valid_q || s1_fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= code_byte_i;
    end
  end

  erld_decode u_decode (
    .phase_i      (phase_q),
    .run_count_i  (run_count_q),
    .bytes_left_i (bytes_left_q),
    .line_bytes_i (line_bytes_q),
    .rle_enable_i (rle_enable_q),
    .code_byte_i  (s1_byte_q),
    .dec_o        (dec)
  );

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      run_count_q  <= 8'd0;
      bytes_left_q <= 16'd0;
    end else if (s1_fire) begin
      phase_q      <= dec.phase_nxt;
      run_count_q  <= dec.run_count_nxt;
      bytes_left_q <= dec.bytes_left_nxt;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_value_q    <= dec.value;
      out_repeat_q   <= dec.repeat_res;
      out_line_end_q <= dec.line_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = out_value_q;
  assign repeat_res_o = out_repeat_q;
  assign line_end_o   = out_line_end_q;

  // checks
  a_repeat_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_repeat_q != 9'd0))
    else $error("run of zero length");

  a_line_end_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> ((bytes_left_q == 16'd0) == out_line_end_q))
    else $error("line end flag disagrees with bytes left");

  a_raw_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && !rle_enable_q) |=> (phase_q == PH_IDLE))
    else $error("raw mode left a half-read escape open");

  a_raw_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && !rle_enable_q) |=> (out_repeat_q == 9'd1))
    else $error("raw mode run longer than one byte");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !res_load)
    else $error("held result overwritten");

endmodule

`default_nettype wire

>>> dv/rle_run_checker.sv
`default_nettype none

module rle_run_checker import erld_pkg::*; (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        cfg_we_i,
  input  var logic        cfg_idx_i,
  input  var logic [15:0] cfg_wdata_i,
  input  var logic        in_valid_i,
  input  var logic        in_ready_i,
  input  var logic [7:0]  code_byte_i,
  input  var logic        out_valid_i,
  input  var logic        out_ready_i,
  input  var logic [7:0]  value_i,
  input  var logic [8:0]  repeat_res_i,
  input  var logic        line_end_i,
  output int              fail_count_o,
  output int              runs_pending_o,
  output int              runs_checked_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] value;
    logic [8:0] repeat_res;
    logic       line_end;
  } run_t;

  // mirror of the decoder registers and state
  logic [15:0] line_len   = 16'd1;
  logic        rle_on     = 1'b1;
  phase_e      ph         = PH_IDLE;
  logic [7:0]  run_cnt    = 8'd0;
  logic [15:0] bytes_open = 16'd0;

  run_t runs_due [$];

  // decode one byte, returns 1 when it closes a run
  function automatic bit decode_byte(input logic [7:0] b, output run_t r);
    logic [8:0]  count;
    logic [16:0] left;
    logic [8:0]  rep;
    bit          emit;
    emit  = 1'b0;
    count = 9'd1;
    r     = '0;
    if (!rle_on) begin
      // raw mode drops any half-read escape
      ph      = PH_IDLE;
      r.value = b;
      emit    = 1'b1;
    end else begin
      case (ph)
        PH_COUNT: begin
          if (b == 8'h00) begin
            ph      = PH_IDLE;
            r.value = EscByte;
            emit    = 1'b1;
          end else begin
            run_cnt = b;
            ph      = PH_VALUE;
          end
        end
        PH_VALUE: begin
          ph      = PH_IDLE;
          r.value = b;
          count   = {1'b0, run_cnt} + 9'd1;
          emit    = 1'b1;
        end
        default: begin
          if (b == EscByte) begin
            ph = PH_COUNT;
          end else begin
            ph      = PH_IDLE;
            r.value = b;
            emit    = 1'b1;
          end
        end
      endcase
    end
    // cut the run at line end, zero length counts as one
    if (emit) begin
      left = {1'b0, bytes_open};
      if (left == 17'd0) begin
        left = (line_len == 16'd0) ? 17'd1 : {1'b0, line_len};
      end
      rep          = ({8'd0, count} < left) ? count : left[8:0];
      left         = left - {8'd0, rep};
      bytes_open   = left[15:0];
      r.repeat_res = rep;
      r.line_end   = (left == 17'd0);
    end
    return emit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    run_t got;
    run_t due;
    bit   bad;
    if (!rst_ni) begin
      line_len   = 16'd1;
      rle_on     = 1'b1;
      ph         = PH_IDLE;
      run_cnt    = 8'd0;
      bytes_open = 16'd0;
      runs_due.delete();
      fail_count_o   <= 0;
      runs_pending_o <= 0;
      runs_checked_o <= 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgLineBytes) begin
          line_len = cfg_wdata_i;
        end else if (cfg_idx_i == CfgRleEnable) begin
          rle_on = cfg_wdata_i[0];
        end
      end
      // compare a taken run against the oldest one due
      if (out_valid_i && out_ready_i) begin
        got = '{value: value_i, repeat_res: repeat_res_i, line_end: line_end_i};
        if (runs_due.size() == 0) begin
          $display("%0t: unexpected run value %h repeat %0d line_end %b",
                   $time, got.value, got.repeat_res, got.line_end);
          fail_count_o <= fail_count_o + 1;
        end else begin
          due = runs_due.pop_front();
          bad = 1'b0;
          if (got.value !== due.value) begin
            $display("%0t: value mismatch, expected %h, got %h", $time, due.value, got.value);
            bad = 1'b1;
          end
          if (got.repeat_res !== due.repeat_res) begin
            $display("%0t: repeat mismatch, expected %0d, got %0d",
                     $time, due.repeat_res, got.repeat_res);
            bad = 1'b1;
          end
          if (got.line_end !== due.line_end) begin
            $display("%0t: line_end mismatch, expected %b, got %b",
                     $time, due.line_end, got.line_end);
            bad = 1'b1;
          end
          if (bad) fail_count_o <= fail_count_o + 1;
          runs_checked_o <= runs_checked_o + 1;
        end
      end
      // each taken request may close a run
      if (in_valid_i && in_ready_i) begin
        if (decode_byte(code_byte_i, due)) runs_due.push_back(due);
      end
      runs_pending_o <= runs_due.size();
    end
  end

endmodule

`default_nettype wire

>>> dv/tb_escape_rle_line_decoder.sv
`default_nettype none

module tb_escape_rle_line_decoder import erld_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int SetBytes   = 230;

  // per-setting line lengths and decode modes, first line length is random
  localparam logic [15:0] LineTable [8] = '{16'd40, 16'hFFFF, 16'd1, 16'd7,
                                            16'd300, 16'd0, 16'd256, 16'd13};
  localparam logic        RleTable  [8] = '{1'b1, 1'b1, 1'b1, 1'b0,
                                            1'b1, 1'b1, 1'b1, 1'b0};
  localparam int IdleSend  [4] = '{0, 73, 0, 17};
  localparam int IdleStall [4] = '{0, 0, 73, 17};

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_we      = 1'b0;
  logic        cfg_idx     = CfgLineBytes;
  logic [15:0] cfg_wdata   = 16'd0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [7:0]  code_byte   = 8'd0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [7:0]  value;
  logic [8:0]  repeat_res;
  logic        line_end;

  int fail_count;
  int runs_pending;
  int runs_checked;
  int cycles      = 0;
  int bytes_sent  = 0;
  int settings    = 0;
  int send_idle   = 0;
  int rcv_stall   = 0;

  escape_rle_line_decoder DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .code_byte_i  (code_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .value_o      (value),
    .repeat_res_o (repeat_res),
    .line_end_o   (line_end)
  );

  rle_run_checker run_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .code_byte_i    (code_byte),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .value_i        (value),
    .repeat_res_i   (repeat_res),
    .line_end_i     (line_end),
    .fail_count_o   (fail_count),
    .runs_pending_o (runs_pending),
    .runs_checked_o (runs_checked)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timed out after %0d cycles, %0d runs outstanding", cycles, runs_pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_stall);
  end

  // one request, with optional idle cycles in front
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    code_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // hold off until every run due has come out and the pipe is empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (runs_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write both registers on back-to-back cycles
  task automatic set_config(input logic [15:0] line_len, input logic rle_on);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgLineBytes;
    cfg_wdata <= line_len;
    @(negedge clk);
    cfg_idx   <= CfgRleEnable;
    cfg_wdata <= {15'd0, rle_on};
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings++;
  endtask

  // mostly well-formed escape sequences, some stray bytes
  task automatic push_sequence();
    int unsigned roll;
    int unsigned n;
    logic [7:0]  b;
    roll = $urandom_range(99);
    if (roll < 40) begin
      b = 8'($urandom_range(255));
      while (b == EscByte) b = 8'($urandom_range(255));
      push_byte(b);
    end else if (roll < 50) begin
      push_byte(EscByte);
      push_byte(8'h00);
    end else if (roll < 85) begin
      n = $urandom_range(99);
      if (n < 70) b = 8'($urandom_range(1, 8));
      else if (n < 90) b = 8'($urandom_range(9, 254));
      else b = 8'hFF;
      push_byte(EscByte);
      push_byte(b);
      push_byte(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) push_byte(8'($urandom_range(255)));
    end
  endtask

  initial begin : stimulus
    int start;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: one byte lines
    push_byte(8'h00);
    push_byte(8'hFF);
    wait_drained();

    // literals, escaped escape, full run cut at line end, escape as run value
    set_config(16'd10, 1'b1);
    push_byte(8'h7F);
    push_byte(EscByte); push_byte(8'h00);
    push_byte(EscByte); push_byte(8'hFF); push_byte(8'hAB);
    push_byte(EscByte); push_byte(8'h01); push_byte(EscByte);
    push_byte(EscByte); push_byte(EscByte); push_byte(8'h55);
    push_byte(8'h01);
    wait_drained();

    // zero line length acts as one
    set_config(16'd0, 1'b1);
    push_byte(EscByte); push_byte(8'h03); push_byte(8'h11);
    push_byte(8'h22);
    wait_drained();

    // shorter line set mid-line only applies from the next line
    set_config(16'd1000, 1'b1);
    push_byte(EscByte); push_byte(8'h04); push_byte(8'h44);
    wait_drained();
    set_config(16'd3, 1'b1);
    push_byte(EscByte); push_byte(8'h10); push_byte(8'h66);
    push_byte(8'h77);

    // half-read escape dropped by raw mode
    push_byte(EscByte);
    wait_drained();
    set_config(16'd3, 1'b0);
    push_byte(EscByte);
    push_byte(8'h05);
    push_byte(8'h00);
    wait_drained();

    // random sequences over several settings and idle patterns
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      send_idle = IdleSend[p % 4];
      rcv_stall = IdleStall[p % 4];
      set_config((p == 0) ? 16'($urandom_range(2, 64)) : LineTable[p], RleTable[p]);
      start = bytes_sent;
      while (bytes_sent - start < SetBytes) begin
        if (p == 3 && bytes_sent - start >= SetBytes / 2 && bytes_sent - start < SetBytes / 2 + 3)
        begin
          wait_drained();
        end
        push_sequence();
      end
    end

    // drain and settle
    send_idle = 0;
    rcv_stall = 0;
    wait_drained();
    repeat (8) @(negedge clk);

    $display("covered %0d encoded bytes under %0d register settings, %0d runs compared",
             bytes_sent, settings, runs_checked);
    if (fail_count == 0 && runs_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failing runs, %0d runs never returned", fail_count, runs_pending);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/erld_pkg.sv
hw/rtl/erld_decode.sv
hw/rtl/escape_rle_line_decoder.sv
dv/rle_run_checker.sv
dv/tb_escape_rle_line_decoder.sv
